[hdl/bgd_pkg.sv]
package bgd_pkg;

	// Field widths of the block.
	localparam int unsigned TimeW  = 16;
	localparam int unsigned DebW   = 8;
	localparam int unsigned CodeW  = 4;
	localparam int unsigned KindW  = 2;
	localparam int unsigned CountW = 2;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned DataW  = 16;

	typedef logic [KindW-1:0]  kind_t;
	typedef logic [CodeW-1:0]  code_t;
	typedef logic [TimeW-1:0]  tick_t;
	typedef logic [DebW-1:0]   deb_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [IdxW-1:0]   idx_t;

	// Trigger kinds.
	localparam kind_t KIND_NONE   = 2'd0;
	localparam kind_t KIND_CLICK  = 2'd1;
	localparam kind_t KIND_DOUBLE = 2'd2;
	localparam kind_t KIND_LONG   = 2'd3;

	// Register indexes.
	localparam idx_t REG_DCT    = 3'd0;
	localparam idx_t REG_LPT    = 3'd1;
	localparam idx_t REG_DEB    = 3'd2;
	localparam idx_t REG_CLICK  = 3'd3;
	localparam idx_t REG_DOUBLE = 3'd4;
	localparam idx_t REG_LONG   = 3'd5;

	// Register reset values.
	localparam tick_t RST_DCT = 16'd3000;
	localparam tick_t RST_LPT = 16'd6000;
	localparam deb_t  RST_DEB = 8'd20;

	// Click count values.
	localparam count_t CNT_NONE = 2'd0;
	localparam count_t CNT_ONE  = 2'd1;
	localparam count_t CNT_TWO  = 2'd2;

endpackage

[hdl/button_gesture_detector_top.sv]
// Push-button gesture classifier. Each accepted item is one sample of an
// active-low button (pin_level 0 means pressed), and each sample yields exactly
// one result item: a trigger kind (none, click, double click, long press) and
// the event code configured for it. The whole step is done in the cycle the
// sample is accepted and lands in an output register, so one sample is taken
// every clock cycle as long as the output side keeps taking results. The
// registers are written through cfg_wr_en, cfg_index and cfg_data; the user
// must do so only while no result is pending; the block does not enforce it.
module button_gesture_detector_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   pin_level,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bgd_pkg::kind_t         trigger_kind,
	output bgd_pkg::code_t         event_code,
	input  logic                   cfg_wr_en,
	input  bgd_pkg::idx_t          cfg_index,
	input  logic [bgd_pkg::DataW-1:0] cfg_data
);
	import bgd_pkg::*;

	// Configuration registers.
	tick_t  dct_q, lpt_q;
	deb_t   deb_ticks_q;
	code_t  click_ev_q, double_ev_q, long_ev_q;

	// Gesture state.
	tick_t  timer_q;
	deb_t   deb_cnt_q;
	logic   stable_q;
	count_t clicks_q;

	// Result register.
	logic   out_valid_q;
	kind_t  kind_q;
	code_t  code_q;

	// Next-state values of one step.
	tick_t  timer_d;
	deb_t   deb_cnt_d;
	logic   stable_d;
	count_t clicks_d;
	kind_t  kind_d;
	code_t  code_d;
	logic   done;
	logic   accept;
	tick_t  timer_inc;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign timer_inc = timer_q + tick_t'(1);

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dct_q       <= RST_DCT;
			lpt_q       <= RST_LPT;
			deb_ticks_q <= RST_DEB;
			click_ev_q  <= '0;
			double_ev_q <= '0;
			long_ev_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DCT:    dct_q       <= cfg_data;
				REG_LPT:    lpt_q       <= cfg_data;
				REG_DEB:    deb_ticks_q <= cfg_data[DebW-1:0];
				REG_CLICK:  click_ev_q  <= cfg_data[CodeW-1:0];
				REG_DOUBLE: double_ev_q <= cfg_data[CodeW-1:0];
				REG_LONG:   long_ev_q   <= cfg_data[CodeW-1:0];
				default: ;
			endcase
		end
	end

	// One step: timer, then debounce, then edge handling.
	always_comb begin
		timer_d   = timer_q;
		deb_cnt_d = deb_cnt_q;
		stable_d  = stable_q;
		clicks_d  = clicks_q;
		kind_d    = KIND_NONE;
		done      = 1'b0;

		// The gesture timer runs until the long-press timeout.
		if (timer_q < lpt_q) begin
			timer_d = timer_inc;
			if (timer_inc == dct_q && stable_q && clicks_q == CNT_ONE) begin
				kind_d   = KIND_CLICK;
				timer_d  = lpt_q;
				clicks_d = CNT_NONE;
				done     = 1'b1;
			end else if (timer_inc == lpt_q) begin
				timer_d  = lpt_q;
				clicks_d = CNT_NONE;
				if (!stable_q && clicks_q == CNT_ONE) begin
					kind_d = KIND_LONG;
					done   = 1'b1;
				end
			end
		end

		// Debounce window swallows the sample.
		if (!done) begin
			if (deb_cnt_q < deb_ticks_q) begin
				deb_cnt_d = deb_cnt_q + deb_t'(1);
			end else if (!pin_level && stable_q) begin
				// Press edge.
				stable_d  = 1'b0;
				deb_cnt_d = '0;
				if (clicks_d == CNT_NONE) begin
					timer_d = '0;
				end
				if (clicks_d != CNT_TWO) begin
					clicks_d = clicks_d + count_t'(1);
				end
			end else if (pin_level && !stable_q) begin
				// Release edge.
				stable_d  = 1'b1;
				deb_cnt_d = '0;
				if (clicks_d == CNT_ONE && (double_ev_q == '0 ||
						(timer_d >= dct_q && timer_d < lpt_q))) begin
					kind_d   = KIND_CLICK;
					timer_d  = lpt_q;
					clicks_d = CNT_NONE;
				end else if (clicks_d == CNT_TWO) begin
					kind_d   = KIND_DOUBLE;
					timer_d  = lpt_q;
					clicks_d = CNT_NONE;
				end
			end
		end

		// Map the trigger to its event code.
		unique case (kind_d)
			KIND_NONE:   code_d = '0;
			KIND_CLICK:  code_d = click_ev_q;
			KIND_DOUBLE: code_d = double_ev_q;
			KIND_LONG:   code_d = long_ev_q;
		endcase
	end

	// State update on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= RST_LPT;
			deb_cnt_q <= RST_DEB;
			stable_q  <= 1'b1;
			clicks_q  <= CNT_NONE;
		end else if (accept) begin
			timer_q   <= timer_d;
			deb_cnt_q <= deb_cnt_d;
			stable_q  <= stable_d;
			clicks_q  <= clicks_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_d;
			code_q <= code_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign trigger_kind = kind_q;
	assign event_code   = code_q;

	// The click count saturates at two.
	assert property (@(posedge clk) disable iff (!arst_n) clicks_q != 2'd3)
		else $error("click count out of range");

	// No result reports a code without a trigger.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_kind == KIND_NONE |-> event_code == '0)
		else $error("event code without trigger");

	// A pending result that is not taken blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted over a pending result");

	// An accepted sample always yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

endmodule

[tb/button_gesture_detector_top_tb.sv]
module button_gesture_detector_top_tb;

	import bgd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 130;
	localparam int unsigned PHASES      = 8;

	// Register indexes beyond the last register; writes to them must change nothing.
	localparam idx_t REG_SPARE_A = REG_LONG + 3'd1;
	localparam idx_t REG_SPARE_B = REG_LONG + 3'd2;

	typedef struct packed {
		kind_t kind;
		code_t code;
	} gesture_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              pin_level = 1'b1;
	logic              out_valid;
	logic              out_ready = 1'b0;
	kind_t             trigger_kind;
	code_t             event_code;
	logic              cfg_wr_en = 1'b0;
	idx_t              cfg_index = REG_DCT;
	logic [DataW-1:0]  cfg_data = '0;

	// Samples waiting to be driven and results waiting to be seen.
	logic              sample_q[$];
	gesture_t          gesture_q[$];
	int unsigned       sent_count = 0;
	int unsigned       done_count = 0;
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;
	logic              in_taken = 1'b0;
	logic              stall_en = 1'b0;
	int unsigned       in_gap = 0;
	int unsigned       out_hold = 0;

	// Copy of the registers and of the gesture state.
	tick_t             m_dct;
	tick_t             m_lpt;
	deb_t              m_deb;
	code_t             m_click_ev;
	code_t             m_double_ev;
	code_t             m_long_ev;
	tick_t             g_timer;
	deb_t              g_deb_cnt;
	logic              g_level;
	count_t            g_clicks;

	button_gesture_detector_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pin_level    (pin_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trigger_kind (trigger_kind),
		.event_code   (event_code),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Closing a gesture, whether reported or abandoned.
	function automatic void close_gesture();
		g_timer = m_lpt;
		g_clicks = CNT_NONE;
	endfunction

	function automatic code_t code_for(input kind_t kind);
		case (kind)
			KIND_CLICK:  return m_click_ev;
			KIND_DOUBLE: return m_double_ev;
			KIND_LONG:   return m_long_ev;
			default:     return '0;
		endcase
	endfunction

	// One tick of the classifier: timer first, then debounce, then edges.
	function automatic kind_t classify_sample(input logic pin);
		logic held;
		if (g_timer < m_lpt) begin
			g_timer = g_timer + tick_t'(1);
			if (g_timer == m_dct && g_level && g_clicks == CNT_ONE) begin
				close_gesture();
				return KIND_CLICK;
			end
			if (g_timer == m_lpt) begin
				held = !g_level && g_clicks == CNT_ONE;
				close_gesture();
				if (held)
					return KIND_LONG;
			end
		end
		if (g_deb_cnt < m_deb) begin
			g_deb_cnt = g_deb_cnt + deb_t'(1);
			return KIND_NONE;
		end
		if (!pin && g_level) begin
			g_level = 1'b0;
			g_deb_cnt = '0;
			if (g_clicks == CNT_NONE)
				g_timer = '0;
			if (g_clicks != CNT_TWO)
				g_clicks = g_clicks + count_t'(1);
		end else if (pin && !g_level) begin
			g_level = 1'b1;
			g_deb_cnt = '0;
			if (g_clicks == CNT_ONE && (m_double_ev == '0 ||
					(g_timer >= m_dct && g_timer < m_lpt))) begin
				close_gesture();
				return KIND_CLICK;
			end else if (g_clicks == CNT_TWO) begin
				close_gesture();
				return KIND_DOUBLE;
			end
		end
		return KIND_NONE;
	endfunction

	// Result checking and prediction at the rising edge.
	always @(posedge clk) begin : monitor
		gesture_t want;
		in_taken = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (gesture_q.size() == 0) begin
					$error("result item with no item outstanding: trigger_kind %0d",
						trigger_kind);
					fail_count++;
				end else begin
					want = gesture_q.pop_front();
					if (trigger_kind !== want.kind) begin
						$error("trigger_kind: expected %0d, actual %0d", want.kind,
							trigger_kind);
						fail_count++;
					end
					if (event_code !== want.code) begin
						$error("event_code: expected %0d, actual %0d", want.code,
							event_code);
						fail_count++;
					end
					done_count++;
				end
			end
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				want.kind = classify_sample(pin_level);
				want.code = code_for(want.kind);
				gesture_q.push_back(want);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		if (arst_n)
			cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** button_gesture_detector_top: FAILED **");
			$finish;
		end
	end

	// Sample driver: holds an item until it is taken, with random gaps between items.
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// Item still waiting to be taken.
		end else if (in_gap != 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (stall_en && sample_q.size() != 0 && $urandom_range(0, 11) == 0) begin
			in_gap <= $urandom_range(0, 13);
			in_valid <= 1'b0;
		end else if (sample_q.size() != 0) begin
			in_valid <= 1'b1;
			pin_level <= sample_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result side: ready most of the time, with random stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_hold != 0) begin
			out_hold <= out_hold - 1;
			out_ready <= 1'b0;
		end else if (stall_en && $urandom_range(0, 15) == 0) begin
			out_hold <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic queue_level(input logic lvl, input int unsigned n);
		repeat (n) begin
			sample_q.push_back(lvl);
			sent_count++;
		end
	endtask

	// One edge to the given level, sometimes with contact bounce, then a hold.
	task automatic queue_edge(input logic lvl, input int span);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				queue_level(lvl, 1);
				queue_level(~lvl, 1);
			end
		end
		queue_level(lvl, $urandom_range(1, span + 3));
	endtask

	// A random gesture scaled to the current timeouts, or a burst of noise.
	task automatic queue_gesture();
		int span;
		int presses;
		span = (m_lpt > m_dct) ? int'(m_lpt) : int'(m_dct);
		if (span > 40)
			span = 40;
		if (span < 2)
			span = 2;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				queue_level(1'($urandom_range(0, 1)), 1);
		end else begin
			presses = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2);
			repeat (presses) begin
				queue_edge(1'b0, span);
				queue_edge(1'b1, span);
			end
			queue_level(1'b1, $urandom_range(0, span + 3));
		end
	endtask

	// Unused upper data bits of the narrow registers carry random junk.
	task automatic write_reg(input idx_t idx, input int unsigned value);
		logic [DataW-1:0] data;
		logic [31:0]      junk;
		data = value[DataW-1:0];
		junk = $urandom();
		case (idx)
			REG_DEB:
				data[DataW-1:DebW] = junk[DataW-DebW-1:0];
			REG_CLICK, REG_DOUBLE, REG_LONG:
				data[DataW-1:CodeW] = junk[DataW-CodeW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_DCT:    m_dct = data;
			REG_LPT:    m_lpt = data;
			REG_DEB:    m_deb = data[DebW-1:0];
			REG_CLICK:  m_click_ev = data[CodeW-1:0];
			REG_DOUBLE: m_double_ev = data[CodeW-1:0];
			REG_LONG:   m_long_ev = data[CodeW-1:0];
			default: ;
		endcase
	endtask

	// Waits until every result is in, then lets the output stage settle.
	task automatic wait_drained();
		wait (done_count == sent_count);
		repeat (2) @(negedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		int unsigned budget;
		int unsigned dct;
		m_dct = RST_DCT;
		m_lpt = RST_LPT;
		m_deb = RST_DEB;
		m_click_ev = '0;
		m_double_ev = '0;
		m_long_ev = '0;
		g_timer = RST_LPT;
		g_deb_cnt = RST_DEB;
		g_level = 1'b1;
		g_clicks = CNT_NONE;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: the press is taken, but the release falls inside the debounce
		// window, so no trigger is reported.
		queue_level(1'b1, 2);
		queue_level(1'b0, 3);
		queue_level(1'b1, 2);
		wait_drained();

		// Short timeouts: click at a release after dct, double click, long press.
		write_reg(REG_DCT, 5);
		write_reg(REG_LPT, 8);
		write_reg(REG_DEB, 1);
		write_reg(REG_CLICK, 1);
		write_reg(REG_DOUBLE, 2);
		write_reg(REG_LONG, 3);
		queue_level(1'b0, 2);
		queue_level(1'b1, 5);
		queue_level(1'b0, 2);
		queue_level(1'b1, 2);
		queue_level(1'b0, 2);
		queue_level(1'b1, 2);
		queue_level(1'b0, 9);
		queue_level(1'b1, 2);
		wait_drained();

		// Long-press timeout lowered below a running timer: the timer freezes.
		queue_level(1'b0, 3);
		wait_drained();
		write_reg(REG_LPT, 1);
		queue_level(1'b1, 3);
		queue_level(1'b0, 3);
		queue_level(1'b1, 3);

		// Random gestures under a series of settings.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_reg(REG_DCT, 0);
					write_reg(REG_LPT, 0);
					write_reg(REG_DEB, 0);
					write_reg(REG_CLICK, 15);
					write_reg(REG_DOUBLE, 15);
					write_reg(REG_LONG, 15);
				end
				1: begin
					// Long-press timeout below the double-click timeout.
					dct = $urandom_range(8, 30);
					write_reg(REG_DCT, dct);
					write_reg(REG_LPT, $urandom_range(2, dct - 1));
					write_reg(REG_DEB, $urandom_range(0, 3));
				end
				2: begin
					write_reg(REG_DCT, 16'hFFFF);
					write_reg(REG_LPT, 16'hFFFF);
					write_reg(REG_DEB, 8'hFF);
				end
				3: begin
					dct = $urandom_range(1, 12);
					write_reg(REG_DCT, dct);
					write_reg(REG_LPT, $urandom_range(dct, 30));
					write_reg(REG_DEB, $urandom_range(0, 4));
					write_reg(REG_CLICK, $urandom_range(1, 15));
					write_reg(REG_DOUBLE, 0);
				end
				default: begin
					if (ph == 4) begin
						write_reg(REG_SPARE_A, $urandom_range(0, 16'hFFFF));
						write_reg(REG_SPARE_B, $urandom_range(0, 16'hFFFF));
					end
					if ($urandom_range(0, 1))
						write_reg(REG_DCT, $urandom_range(1, 20));
					if ($urandom_range(0, 1) || m_lpt < m_dct)
						write_reg(REG_LPT, int'(m_dct) + $urandom_range(0, 25));
					if ($urandom_range(0, 1))
						write_reg(REG_DEB, $urandom_range(0, 6));
					if ($urandom_range(0, 1))
						write_reg(REG_CLICK, $urandom_range(0, 15));
					if ($urandom_range(0, 1))
						write_reg(REG_DOUBLE, $urandom_range(0, 15));
					if ($urandom_range(0, 1))
						write_reg(REG_LONG, $urandom_range(0, 15));
				end
			endcase
			// Some phases run without idling, and the last one always does.
			stall_en = (ph != PHASES - 1) && (ph % 3 != 1);
			budget = sent_count + PHASE_ITEMS;
			while (sent_count < budget)
				queue_gesture();
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (fail_count == 0 && gesture_q.size() == 0) begin
			$display("** button_gesture_detector_top: PASSED **");
		end else begin
			$display("** button_gesture_detector_top: FAILED **");
		end
		$finish;
	end

endmodule
